>>> rtl/polygon_area_bbox_center_defines.svh
// Assertion macros for the polygon area and bounding box block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef POLYGON_AREA_BBOX_CENTER_DEFINES_SVH
`define POLYGON_AREA_BBOX_CENTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("invariant violated");
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sequence check failed");
`else
`define ASSERT_HOLDS(name, expr)
`define ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> rtl/pabc_pkg.sv
package pabc_pkg;

  localparam int COORD_W    = 24;
  localparam int CENTER_W   = COORD_W + 1;
  localparam int TERM_W     = 2 * CENTER_W;
  localparam int SUM_W      = 64;
  localparam int AREA_W     = 50;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 200;
  localparam int OUT_PAD_W  = OUT_DATA_W - AREA_W - 4 * COORD_W - 2 * CENTER_W;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]          AREA_LIMIT = SUM_W'(1) << (2 * COORD_W + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
  } bbox_t;

  // Add a shoelace term to the running sum, clamping at the signed limits.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  acc,
    input logic signed [TERM_W-1:0] term
  );
    logic [SUM_W:0] wide;
    wide = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - TERM_W){term[TERM_W-1]}}, term};
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sat_add = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_add = wide[SUM_W-1:0];
    end
  endfunction

endpackage

>>> rtl/polygon_area_bbox_center.sv
// Streaming polygon area and bounding box. Vertices arrive one transaction
// per cycle on the slave side: tdata carries x and y as signed values with
// 4 fraction bits, tlast marks the closing vertex and tuser flags an empty
// polygon (coordinates ignored, result all zeros, any partial polygon is
// dropped). Each closed polygon yields exactly one master-side transaction
// holding the absolute shoelace area in 1/512 square pixel (saturated at
// 2^49), the bounding box and its center as min plus max in 1/32 pixel.
// Vertices that do not close a polygon produce nothing. The block sustains
// one vertex per cycle unless master-side back-pressure fills the stages; a
// closing vertex passes the input register, product stage with two 25x25
// multipliers, running-sum stage, closing-term stage and output register.
// Every stage has its own valid bit, so the slave side keeps accepting while
// a result waits on the master side until the stages ahead fill up.
`include "polygon_area_bbox_center_defines.svh"

module polygon_area_bbox_center (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [23:0] x_coord, [47:24] y_coord
  input  logic [pabc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tlast,   // last_point
  input  logic                             s_axis_tuser,   // no_point
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [49:0] area_q9, [73:50] min_x, [97:74] min_y, [121:98] max_x,
  // [145:122] max_y, [170:146] center_x, [195:171] center_y, [199:196] zero
  output logic [pabc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import pabc_pkg::*;

  // ---------------------------------------------------------------------
  // Handshake: each stage advances when the one ahead is empty or moving.
  // ---------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q, mv_q;
  logic end1_q;
  logic out_rdy, rdy3, rdy2, rdy1;
  logic adv3, adv2, adv1, adv0;
  logic take;

  assign out_rdy = !mv_q || m_axis_tready;
  assign rdy3    = !v3_q || out_rdy;
  assign adv3    = v3_q && out_rdy;
  assign rdy2    = !v2_q || rdy3;
  assign adv2    = v2_q && rdy3;
  // Vertices that do not close a polygon only feed the running sum.
  assign adv1    = v1_q && (!end1_q || rdy2);
  assign rdy1    = !v1_q || adv1;
  assign adv0    = v0_q && rdy1;

  assign s_axis_tready = !v0_q || rdy1;
  assign take          = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // Stage 0: input register.
  // ---------------------------------------------------------------------
  logic signed [COORD_W-1:0] x0_q, y0_q;
  logic                      last0_q, np0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (s_axis_tready) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x0_q    <= s_axis_tdata[COORD_W-1:0];
      y0_q    <= s_axis_tdata[2*COORD_W-1:COORD_W];
      last0_q <= s_axis_tlast;
      np0_q   <= s_axis_tuser;
    end
  end

  // ---------------------------------------------------------------------
  // Polygon state: first and previous vertex, running bounding box.
  // Updated as a vertex leaves stage 0; cleared when a polygon ends.
  // ---------------------------------------------------------------------
  logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_W-1:0] fx, fy;
  logic                      in_poly_q;
  bbox_t                     box_q, box_d;
  logic                      poly_end0;

  assign poly_end0 = last0_q || np0_q;
  assign fx        = in_poly_q ? first_x_q : x0_q;
  assign fy        = in_poly_q ? first_y_q : y0_q;

  always_comb begin
    box_d.min_x = (x0_q < box_q.min_x) ? x0_q : box_q.min_x;
    box_d.min_y = (y0_q < box_q.min_y) ? y0_q : box_q.min_y;
    box_d.max_x = (x0_q > box_q.max_x) ? x0_q : box_q.max_x;
    box_d.max_y = (y0_q > box_q.max_y) ? y0_q : box_q.max_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      in_poly_q   <= 1'b0;
      box_q.min_x <= COORD_MAX;
      box_q.min_y <= COORD_MAX;
      box_q.max_x <= COORD_MIN;
      box_q.max_y <= COORD_MIN;
    end else if (adv0) begin
      if (poly_end0) begin
        first_x_q   <= '0;
        first_y_q   <= '0;
        prev_x_q    <= '0;
        prev_y_q    <= '0;
        in_poly_q   <= 1'b0;
        box_q.min_x <= COORD_MAX;
        box_q.min_y <= COORD_MAX;
        box_q.max_x <= COORD_MIN;
        box_q.max_y <= COORD_MIN;
      end else begin
        first_x_q <= fx;
        first_y_q <= fy;
        prev_x_q  <= x0_q;
        prev_y_q  <= y0_q;
        in_poly_q <= 1'b1;
        box_q     <= box_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: shoelace products. t1 links previous to current vertex, t2
  // closes current back to first; t2 matters only on a closing vertex.
  // ---------------------------------------------------------------------
  logic signed [CENTER_W-1:0] sx1, dy1, sx2, dy2;
  logic signed [TERM_W-1:0]   t1_d, t2_d, t1_q, t2_1_q;
  logic                       start1_q;
  bbox_t                      box1_q;

  assign sx1  = {prev_x_q[COORD_W-1], prev_x_q} + {x0_q[COORD_W-1], x0_q};
  assign dy1  = {prev_y_q[COORD_W-1], prev_y_q} - {y0_q[COORD_W-1], y0_q};
  assign sx2  = {x0_q[COORD_W-1], x0_q} + {fx[COORD_W-1], fx};
  assign dy2  = {y0_q[COORD_W-1], y0_q} - {fy[COORD_W-1], fy};
  assign t1_d = sx1 * dy1;
  assign t2_d = sx2 * dy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= adv0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      end1_q   <= poly_end0;
      // An empty polygon starts fresh and carries zeros all the way out.
      start1_q <= np0_q || !in_poly_q;
      t1_q     <= np0_q ? '0 : t1_d;
      t2_1_q   <= np0_q ? '0 : t2_d;
      box1_q   <= np0_q ? '0 : box_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: running shoelace sum. Only closing items move on.
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0]  sum_q, part_sum;
  logic signed [SUM_W-1:0]  sum2_q;
  logic signed [TERM_W-1:0] t2_2_q;
  bbox_t                    box2_q;

  assign part_sum = start1_q ? '0 : sat_add(sum_q, t1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (adv1) begin
      sum_q <= end1_q ? '0 : part_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= adv1 && end1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && end1_q && rdy2) begin
      sum2_q <= part_sum;
      t2_2_q <= t2_1_q;
      box2_q <= box1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: add the closing term.
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] final3_q;
  bbox_t                   box3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= adv2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      final3_q <= sat_add(sum2_q, t2_2_q);
      box3_q   <= box2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: magnitude, area clamp and box center.
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]           mag3;
  logic [AREA_W-1:0]          area_d, area_q;
  logic signed [CENTER_W-1:0] cx_d, cy_d, cx_q, cy_q;
  bbox_t                      box_o_q;

  assign mag3   = final3_q[SUM_W-1] ? (SUM_W'(0) - final3_q) : final3_q;
  assign area_d = (mag3 > AREA_LIMIT) ? AREA_LIMIT[AREA_W-1:0] : mag3[AREA_W-1:0];
  assign cx_d   = {box3_q.min_x[COORD_W-1], box3_q.min_x}
                + {box3_q.max_x[COORD_W-1], box3_q.max_x};
  assign cy_d   = {box3_q.min_y[COORD_W-1], box3_q.min_y}
                + {box3_q.max_y[COORD_W-1], box3_q.max_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (out_rdy) begin
      mv_q <= adv3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      area_q  <= area_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      box_o_q <= box3_q;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, cy_q, cx_q, box_o_q.max_y, box_o_q.max_x,
                          box_o_q.min_y, box_o_q.min_x, area_q};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_HOLDS(a_box_ordered, !in_poly_q || ((box_q.min_x <= box_q.max_x) && (box_q.min_y <= box_q.max_y)))
  `ASSERT_NEXT(a_state_cleared, adv0 && poly_end0, !in_poly_q)
  `ASSERT_HOLDS(a_area_limit, !mv_q || ({{(SUM_W-AREA_W){1'b0}}, area_q} <= AREA_LIMIT))
  `ASSERT_NEXT(a_result_after_close, adv2, v3_q)

endmodule

>>> verif/polygon_check_pkg.sv
package polygon_check_pkg;

  import pabc_pkg::*;

  // Fields of one result, held as raw bits in the same widths as the master-side tdata.
  typedef struct {
    logic [AREA_W-1:0]   area;
    logic [COORD_W-1:0]  min_x;
    logic [COORD_W-1:0]  min_y;
    logic [COORD_W-1:0]  max_x;
    logic [COORD_W-1:0]  max_y;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
  } outline_t;

  class polygon_scoreboard;

    int unsigned fault_count;
    outline_t    outline_q[$];

    // Predictor state: one polygon in progress.
    logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
    logic signed [COORD_W-1:0] low_x, low_y, high_x, high_y;
    logic signed [SUM_W-1:0]   area_sum;
    bit                        open;

    function new();
      fault_count = 0;
      clear();
    endfunction

    function void clear();
      first_x  = '0;
      first_y  = '0;
      prev_x   = '0;
      prev_y   = '0;
      area_sum = '0;
      low_x    = COORD_MAX;
      low_y    = COORD_MAX;
      high_x   = COORD_MIN;
      high_y   = COORD_MIN;
      open     = 1'b0;
    endfunction

    // Add one edge term (xa + xb) * (ya - yb), clamped at the 64-bit signed limits.
    function void add_edge(logic signed [COORD_W-1:0] xa, logic signed [COORD_W-1:0] ya,
                           logic signed [COORD_W-1:0] xb, logic signed [COORD_W-1:0] yb);
      logic signed [CENTER_W-1:0] sx;
      logic signed [CENTER_W-1:0] dy;
      logic signed [TERM_W-1:0]   term;
      logic signed [SUM_W:0]      wide;
      sx   = {xa[COORD_W-1], xa} + {xb[COORD_W-1], xb};
      dy   = {ya[COORD_W-1], ya} - {yb[COORD_W-1], yb};
      term = sx * dy;
      wide = (SUM_W+1)'(area_sum) + (SUM_W+1)'(term);
      if (wide > SUM_MAX) begin
        area_sum = SUM_MAX;
      end else if (wide < SUM_MIN) begin
        area_sum = SUM_MIN;
      end else begin
        area_sum = wide[SUM_W-1:0];
      end
    endfunction

    // Take one accepted vertex transaction; queue a result when it closes a polygon.
    function void take_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              bit last, bit empty);
      outline_t           o;
      logic [SUM_W-1:0]   mag;
      if (empty) begin
        o = '{default: '0};
        outline_q = {outline_q, o};
        clear();
        return;
      end
      if (!open) begin
        first_x  = x;
        first_y  = y;
        area_sum = '0;
      end else begin
        add_edge(prev_x, prev_y, x, y);
      end
      prev_x = x;
      prev_y = y;
      open   = 1'b1;
      if (x < low_x)  low_x  = x;
      if (y < low_y)  low_y  = y;
      if (x > high_x) high_x = x;
      if (y > high_y) high_y = y;
      if (!last) return;
      add_edge(x, y, first_x, first_y);
      mag = (area_sum < 0) ? -area_sum : area_sum;
      if (mag > AREA_LIMIT) mag = AREA_LIMIT;
      o.area     = mag[AREA_W-1:0];
      o.min_x    = low_x;
      o.min_y    = low_y;
      o.max_x    = high_x;
      o.max_y    = high_y;
      o.center_x = {low_x[COORD_W-1], low_x} + {high_x[COORD_W-1], high_x};
      o.center_y = {low_y[COORD_W-1], low_y} + {high_y[COORD_W-1], high_y};
      outline_q = {outline_q, o};
      clear();
    endfunction

    function int unsigned waiting();
      return outline_q.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fault_count++;
    endtask

    task compare(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", field, got, want));
    endtask

    // Check one accepted result transaction against the oldest prediction.
    task check_outline(logic [OUT_DATA_W-1:0] d);
      outline_t want;
      if (outline_q.size() == 0) begin
        report($sformatf("result with nothing pending: %h", d));
        return;
      end
      want = outline_q.pop_front();
      compare("area_q9",  64'(d[0 +: AREA_W]),                     64'(want.area));
      compare("min_x",    64'(d[AREA_W +: COORD_W]),               64'(want.min_x));
      compare("min_y",    64'(d[AREA_W + COORD_W +: COORD_W]),     64'(want.min_y));
      compare("max_x",    64'(d[AREA_W + 2 * COORD_W +: COORD_W]), 64'(want.max_x));
      compare("max_y",    64'(d[AREA_W + 3 * COORD_W +: COORD_W]), 64'(want.max_y));
      compare("center_x", 64'(d[AREA_W + 4 * COORD_W +: CENTER_W]), 64'(want.center_x));
      compare("center_y", 64'(d[AREA_W + 4 * COORD_W + CENTER_W +: CENTER_W]),
              64'(want.center_y));
      compare("pad",      64'(d[OUT_DATA_W-1 -: OUT_PAD_W]),       64'(0));
    endtask

  endclass

endpackage

>>> verif/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import pabc_pkg::*;
  import polygon_check_pkg::*;

  // Random part length in items; receiver hold-off length, drain wait and run limit in cycles.
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  // How the coordinates of one polygon are drawn.
  typedef enum int unsigned {
    SPREAD_FULL,   // anywhere in the coordinate range
    SPREAD_NEAR,   // a few hundred steps around the origin
    SPREAD_EDGE,   // range limits, zero and unit steps
    SPREAD_MIXED   // each coordinate picks one of the above
  } coord_style_e;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_W-1:0]     s_axis_tdata  = '0;   // [23:0] x_coord, [47:24] y_coord
  logic                     s_axis_tlast  = 1'b0; // last_point
  logic                     s_axis_tuser  = 1'b0; // no_point
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // [49:0] area_q9, [73:50] min_x, [97:74] min_y, [121:98] max_x,
  // [145:122] max_y, [170:146] center_x, [195:171] center_y, [199:196] zero
  logic [OUT_DATA_W-1:0]    m_axis_tdata;

  polygon_scoreboard sb = new();

  int unsigned gap_pct     = 0;  // chance in percent that the sender idles a cycle
  int unsigned stall_pct   = 0;  // chance in percent that the receiver stalls a cycle
  int unsigned sent_count  = 0;
  int unsigned cycle_count = 0;
  bit          hold_active = 1'b0;
  event        hold_kick;

  polygon_area_bbox_center u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall at random per the current phase, and hold off entirely while a
  // long back-pressure stretch is running.
  always @(negedge clk_i) begin
    m_axis_tready <= !hold_active && (stall_pct == 0 || $urandom_range(99) >= stall_pct);
  end

  // Long hold-off, counted in its own process: once kicked, keep the receiver
  // closed for HOLD_CYCLES so the pipeline fills and the slave side stalls.
  initial begin
    @(hold_kick);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // Result monitor: every accepted master-side transaction goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_outline(m_axis_tdata);
  end

  function automatic logic signed [COORD_W-1:0] pick_coord(coord_style_e style);
    coord_style_e s;
    s = (style == SPREAD_MIXED) ? coord_style_e'($urandom_range(2)) : style;
    case (s)
      SPREAD_FULL: return COORD_W'($urandom());
      SPREAD_NEAR: return COORD_W'($urandom_range(800)) - COORD_W'(400);
      default: begin
        case ($urandom_range(4))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return '0;
          3:       return '1;
          default: return COORD_W'(1);
        endcase
      end
    endcase
  endfunction

  // Offer one vertex transaction and hold it until the block takes it. Enter and
  // leave at a falling edge with nothing yet assigned in that time step.
  task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input bit last, input bit empty);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    s_axis_tuser  <= empty;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_vertex(x, y, last, empty);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Send n vertices; a broken polygon ends in an empty-marked item instead of tlast.
  task automatic send_polygon(input int unsigned n, input coord_style_e style,
                              input bit broken);
    for (int unsigned i = 0; i < n; i++) begin
      send_vertex(pick_coord(style), pick_coord(style), !broken && i == n - 1, 1'b0);
    end
    if (broken) send_vertex(COORD_W'($urandom()), COORD_W'($urandom()),
                            1'($urandom_range(1)), 1'b1);
  endtask

  initial begin
    int unsigned gap_table[4];
    int unsigned stall_table[4];
    int unsigned target;
    int unsigned pick;
    int unsigned n;
    gap_table   = '{0, 47, 0, 32};
    stall_table = '{0, 0, 47, 32};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part.
    // Empty polygons, with and without tlast; coordinates must be ignored.
    send_vertex(COORD_W'($urandom()), COORD_W'($urandom()), 1'b0, 1'b1);
    send_vertex(COORD_W'($urandom()), COORD_W'($urandom()), 1'b1, 1'b1);
    // Single vertex at each range limit: zero area, min equals max.
    send_vertex(COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    // All-negative triangle: the maximum search must not stick at zero.
    send_vertex(-24'sd100, -24'sd50,  1'b0, 1'b0);
    send_vertex(-24'sd20,  -24'sd300, 1'b0, 1'b0);
    send_vertex(-24'sd400, -24'sd10,  1'b1, 1'b0);
    // Full-range rectangle: largest simple area.
    send_vertex(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1, 1'b0);
    // Same rectangle traced twice: the area must saturate.
    for (int i = 0; i < 8; i++) begin
      send_vertex((i % 4 == 1 || i % 4 == 2) ? COORD_MAX : COORD_MIN,
                  (i % 4 >= 2) ? COORD_MAX : COORD_MIN, i == 7, 1'b0);
    end
    // Partial polygon dropped by an empty item.
    send_vertex(24'sd5, 24'sd6, 1'b0, 1'b0);
    send_vertex(24'sd7, 24'sd8, 1'b0, 1'b0);
    send_vertex(COORD_W'($urandom()), COORD_W'($urandom()), 1'b0, 1'b1);
    // Two-vertex degenerate polygon around the origin.
    send_vertex(-24'sd1, 24'sd1,  1'b0, 1'b0);
    send_vertex(24'sd1,  -24'sd1, 1'b1, 1'b0);

    // Random part in four idling phases. Phase boundaries fall between polygons.
    for (int p = 0; p < 4; p++) begin
      gap_pct   = gap_table[p];
      stall_pct = stall_table[p];
      // Start the long receiver hold-off while the sender runs at full rate.
      if (p == 0) -> hold_kick;
      target = sent_count + RANDOM_ITEMS / 4;
      while (sent_count < target) begin
        pick = $urandom_range(99);
        n    = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        if (pick < 6) begin
          // Lone empty item.
          send_vertex(COORD_W'($urandom()), COORD_W'($urandom()),
                      1'($urandom_range(1)), 1'b1);
        end else if (pick < 12) begin
          send_polygon($urandom_range(1, 5), coord_style_e'($urandom_range(3)), 1'b1);
        end else begin
          send_polygon(n, coord_style_e'($urandom_range(3)), 1'b0);
        end
      end
    end

    // Drain: release the sender, keep the receiver open, wait out the pipeline.
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
